### sv/pcma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcma_pkg
// Shared types and constants of the centred moving average over path points.
// ----------------------------------------------------------------------------
package pcma_pkg;

  // Width and reset value of the window half-width register.
  localparam int unsigned WH_W = 5;
  localparam logic [WH_W-1:0] HALF_WIDTH_RESET = 5'd1;

  // Status that the back end reports to the front end.
  typedef struct packed {
    logic q_empty;    // no job waits in the queue
    logic back_idle;  // back end is not reading the ring
  } pipe_status_t;

endpackage

### sv/pcma_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcma_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pcma_queue #(
  parameter int WIDTH = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             not_empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign dout      = slot[rd_ptr];

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### sv/pcma_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcma_front
// Accepts path points, writes them to the ring and issues one averaging job
// per output point whose window is complete.
// ----------------------------------------------------------------------------
module pcma_front import pcma_pkg::*; #(
  parameter int MAX_HALF   = 31,
  parameter int COORD_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [WH_W-1:0]                         half_width,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [COORD_BITS-1:0]                   in_x,
  input  logic [COORD_BITS-1:0]                   in_y,
  input  logic [COORD_BITS-1:0]                   in_z,
  input  logic                                    in_end,
  input  pipe_status_t                            status,
  input  logic                                    q_full,
  output logic                                    ring_we,
  output logic [$clog2(2*MAX_HALF+1)-1:0]         ring_waddr,
  output logic [COORD_BITS-1:0]                   ring_wx,
  output logic [COORD_BITS-1:0]                   ring_wy,
  output logic [COORD_BITS-1:0]                   ring_wz,
  output logic                                    job_push,
  output logic                                    job_last,
  output logic [$clog2(2*MAX_HALF+1)-1:0]         job_start,
  output logic [$clog2(2*MAX_HALF+2)-1:0]         job_cnt
);

  localparam int HW   = $clog2(MAX_HALF + 1);
  localparam int AW   = $clog2(2 * MAX_HALF + 1);
  localparam int CNTW = $clog2(2 * MAX_HALF + 2);

  typedef enum logic [1:0] {
    F_IDLE  = 2'b01,
    F_ISSUE = 2'b10
  } front_state_t;

  front_state_t   state;
  logic [31:0]    points_seen;
  logic [31:0]    next_idx;
  logic [31:0]    cur_i;
  logic           cur_end;
  logic [HW-1:0]  half;
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  cur_wptr;

  logic [HW-1:0]  half_next;
  logic [31:0]    d32;
  logic [HW-1:0]  lag;
  logic           more;
  logic           is_last;
  logic [HW-1:0]  span;
  logic [HW-1:0]  left;
  logic           bypass;
  logic [AW-1:0]  center;
  logic           accept;

  assign in_ready = (state == F_IDLE) && status.q_empty && status.back_idle;
  assign accept   = in_valid && in_ready;

  // Ring write of every accepted point.
  assign ring_we    = accept;
  assign ring_waddr = wptr;
  assign ring_wx    = in_x;
  assign ring_wy    = in_y;
  assign ring_wz    = in_z;

  // Half-width latched at the first point of a path, saturated.
  always_comb begin
    if (points_seen != 32'd0) begin
      half_next = half;
    end else if (32'(half_width) > MAX_HALF) begin
      half_next = HW'(MAX_HALF);
    end else begin
      half_next = HW'(half_width);
    end
  end

  // Job for the next pending output.
  always_comb begin
    d32     = cur_i - next_idx;
    lag     = d32[HW-1:0];
    more    = cur_end || ((next_idx != cur_i + 32'd1) && (d32 >= 32'(half)));
    is_last = cur_end && (next_idx == cur_i);
    if (cur_end && (lag < half)) begin
      span = lag;
    end else begin
      span = half;
    end
    if (next_idx >= 32'(half)) begin
      left = half;
    end else begin
      left = next_idx[HW-1:0];
    end
    bypass = (next_idx == 32'd0) || is_last;
    center = cur_wptr - AW'(lag);
    if (bypass) begin
      job_cnt   = CNTW'(1);
      job_start = center;
    end else begin
      job_cnt   = CNTW'(left) + CNTW'(span) + CNTW'(1);
      job_start = center - AW'(left);
    end
  end

  assign job_last = is_last;
  assign job_push = (state == F_ISSUE) && more && !q_full;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      points_seen <= 32'd0;
      next_idx    <= 32'd0;
      half        <= '0;
      wptr        <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            half        <= half_next;
            cur_i       <= points_seen;
            cur_end     <= in_end;
            cur_wptr    <= wptr;
            wptr        <= wptr + AW'(1);
            points_seen <= points_seen + 32'd1;
            state       <= F_ISSUE;
          end
        end
        F_ISSUE: begin
          if (!more) begin
            state <= F_IDLE;
          end else if (!q_full) begin
            if (is_last) begin
              points_seen <= 32'd0;
              next_idx    <= 32'd0;
              state       <= F_IDLE;
            end else begin
              next_idx <= next_idx + 32'd1;
            end
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/pcma_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcma_back
// Holds the point ring, sums each job's window over cycles, divides by the
// count with rounding and presents the result word.
// ----------------------------------------------------------------------------
module pcma_back #(
  parameter int MAX_HALF   = 31,
  parameter int COORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                ring_we,
  input  logic [$clog2(2*MAX_HALF+1)-1:0]     ring_waddr,
  input  logic [COORD_BITS-1:0]               ring_wx,
  input  logic [COORD_BITS-1:0]               ring_wy,
  input  logic [COORD_BITS-1:0]               ring_wz,
  input  logic                                job_valid,
  output logic                                job_pop,
  input  logic                                job_last,
  input  logic [$clog2(2*MAX_HALF+1)-1:0]     job_start,
  input  logic [$clog2(2*MAX_HALF+2)-1:0]     job_cnt,
  output logic                                back_idle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [COORD_BITS-1:0]               out_x,
  output logic [COORD_BITS-1:0]               out_y,
  output logic [COORD_BITS-1:0]               out_z,
  output logic                                out_last
);

  localparam int AW    = $clog2(2 * MAX_HALF + 1);
  localparam int CNTW  = $clog2(2 * MAX_HALF + 2);
  localparam int DEPTH = 2 ** AW;
  localparam int SUM_W = COORD_BITS + CNTW;
  localparam int BCW   = $clog2(SUM_W + 1);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SUM  = 4'b0010,
    B_DIV  = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_t;

  back_state_t              state;
  logic [COORD_BITS-1:0]    mem_x [DEPTH];
  logic [COORD_BITS-1:0]    mem_y [DEPTH];
  logic [COORD_BITS-1:0]    mem_z [DEPTH];
  logic [COORD_BITS-1:0]    rd [3];
  logic                     rd_vld;
  logic [AW-1:0]            start;
  logic [CNTW-1:0]          cnt;
  logic                     last;
  logic [CNTW-1:0]          issued;
  logic [SUM_W-1:0]         acc [3];
  logic [SUM_W-1:0]         dvd [3];
  logic [CNTW-1:0]          rem [3];
  logic [SUM_W-1:0]         quo [3];
  logic                     neg [3];
  logic [BCW-1:0]           bits;
  logic [COORD_BITS-1:0]    res [3];

  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic [SUM_W-1:0]         rd_ext [3];
  logic [CNTW:0]            r2 [3];
  logic                     ge [3];
  logic [CNTW:0]            r2_sub [3];
  logic [SUM_W-1:0]         qfin [3];
  logic [SUM_W-1:0]         mag [3];

  assign rd_en     = (state == B_SUM) && (issued < cnt);
  assign rd_addr   = start + AW'(issued);
  assign job_pop   = (state == B_IDLE) && job_valid;
  assign back_idle = (state != B_SUM);

  // Ring memory with registered read.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      mem_x[ring_waddr] <= ring_wx;
      mem_y[ring_waddr] <= ring_wy;
      mem_z[ring_waddr] <= ring_wz;
    end
    rd[0] <= mem_x[rd_addr];
    rd[1] <= mem_y[rd_addr];
    rd[2] <= mem_z[rd_addr];
  end

  // Per-axis arithmetic: sign extension, one divider step, final sign.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rd_ext[a] = {{(SUM_W-COORD_BITS){rd[a][COORD_BITS-1]}}, rd[a]};
      mag[a]    = acc[a][SUM_W-1] ? (~acc[a] + SUM_W'(1)) : acc[a];
      r2[a]     = {rem[a], dvd[a][SUM_W-1]};
      ge[a]     = (r2[a] >= {1'b0, cnt});
      r2_sub[a] = r2[a] - {1'b0, cnt};
      qfin[a]   = neg[a] ? (~quo[a] + SUM_W'(1)) : quo[a];
    end
  end

  // Job sequencer: window sum, restoring division, output hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The hand-off state either reloads the word or holds it unaccepted.
      if (out_ready && (state != B_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            start  <= job_start;
            cnt    <= job_cnt;
            last   <= job_last;
            issued <= '0;
            rd_vld <= 1'b0;
            for (int a = 0; a < 3; a++) begin
              acc[a] <= '0;
            end
            state <= B_SUM;
          end
        end
        B_SUM: begin
          rd_vld <= rd_en;
          if (rd_en) begin
            issued <= issued + CNTW'(1);
          end
          if (rd_vld) begin
            for (int a = 0; a < 3; a++) begin
              acc[a] <= acc[a] + rd_ext[a];
            end
          end
          if (!rd_en && !rd_vld) begin
            if (cnt == CNTW'(1)) begin
              // A single point passes through exactly.
              for (int a = 0; a < 3; a++) begin
                res[a] <= acc[a][COORD_BITS-1:0];
              end
              state <= B_OUT;
            end else begin
              for (int a = 0; a < 3; a++) begin
                neg[a] <= acc[a][SUM_W-1];
                dvd[a] <= mag[a] + SUM_W'(cnt >> 1);
                rem[a] <= '0;
                quo[a] <= '0;
              end
              bits  <= BCW'(SUM_W);
              state <= B_DIV;
            end
          end
        end
        B_DIV: begin
          if (bits == '0) begin
            for (int a = 0; a < 3; a++) begin
              res[a] <= qfin[a][COORD_BITS-1:0];
            end
            state <= B_OUT;
          end else begin
            for (int a = 0; a < 3; a++) begin
              rem[a] <= ge[a] ? r2_sub[a][CNTW-1:0] : r2[a][CNTW-1:0];
              dvd[a] <= {dvd[a][SUM_W-2:0], 1'b0};
              quo[a] <= {quo[a][SUM_W-2:0], ge[a]};
            end
            bits <= bits - BCW'(1);
          end
        end
        B_OUT: begin
          if (!out_valid || out_ready) begin
            out_x     <= res[0];
            out_y     <= res[1];
            out_z     <= res[2];
            out_last  <= last;
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/path_centered_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_centered_moving_average
// Centred moving average of 3-D path points, window cut at the path ends.
// The window sum reads one ring point a cycle, then a one-bit-a-cycle divider
// gives the average; a one-point window skips the divider. A new point is
// taken once the back end has started the last job and read its window, so
// without output stalls about one point per job time.
// Reset is synchronous, active high; the half-width register resets to 1.
// ----------------------------------------------------------------------------
module path_centered_moving_average import pcma_pkg::*; #(
  parameter int MAX_HALF   = 31,
  parameter int COORD_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [WH_W-1:0]                        cfg_data,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // pos_x, pos_y, pos_z from the lowest bit up, zero padded to bytes
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                   s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // avg_x, avg_y, avg_z from the lowest bit up, zero padded to bytes
  output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
  output logic                                   m_axis_tlast
);

  localparam int AW     = $clog2(2 * MAX_HALF + 1);
  localparam int CNTW   = $clog2(2 * MAX_HALF + 2);
  localparam int DATA_W = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int JOB_W  = 1 + AW + CNTW;

  logic [WH_W-1:0]       half_width;
  pipe_status_t          status;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  ring_we;
  logic [AW-1:0]         ring_waddr;
  logic [COORD_BITS-1:0] ring_wx;
  logic [COORD_BITS-1:0] ring_wy;
  logic [COORD_BITS-1:0] ring_wz;
  logic                  job_push;
  logic                  job_pop;
  logic                  f_last;
  logic [AW-1:0]         f_start;
  logic [CNTW-1:0]       f_cnt;
  logic [JOB_W-1:0]      q_dout;
  logic                  back_idle;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [COORD_BITS-1:0] out_z;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= HALF_WIDTH_RESET;
    end else if (cfg_valid) begin
      half_width <= cfg_data;
    end
  end

  assign status.q_empty   = !q_not_empty;
  assign status.back_idle = back_idle;

  pcma_front #(
    .MAX_HALF   (MAX_HALF),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .half_width  (half_width),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_x        (s_axis_tdata[COORD_BITS-1:0]),
    .in_y        (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_z        (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .in_end      (s_axis_tlast),
    .status      (status),
    .q_full      (q_full),
    .ring_we     (ring_we),
    .ring_waddr  (ring_waddr),
    .ring_wx     (ring_wx),
    .ring_wy     (ring_wy),
    .ring_wz     (ring_wz),
    .job_push    (job_push),
    .job_last    (f_last),
    .job_start   (f_start),
    .job_cnt     (f_cnt)
  );

  pcma_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .din       ({f_last, f_start, f_cnt}),
    .full      (q_full),
    .pop       (job_pop),
    .dout      (q_dout),
    .not_empty (q_not_empty)
  );

  pcma_back #(
    .MAX_HALF   (MAX_HALF),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_wx    (ring_wx),
    .ring_wy    (ring_wy),
    .ring_wz    (ring_wz),
    .job_valid  (q_not_empty),
    .job_pop    (job_pop),
    .job_last   (q_dout[JOB_W-1]),
    .job_start  (q_dout[JOB_W-2:CNTW]),
    .job_cnt    (q_dout[CNTW-1:0]),
    .back_idle  (back_idle),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = DATA_W'({out_z, out_y, out_x});

  // A point is followed by its job issue phase before the next is taken.
  a_one_point_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("point accepted while the previous one is still issuing");

  // The front end never pushes into a full queue.
  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !q_full)
    else $error("job pushed into a full queue");

  // The ring is never written while the back end reads a window.
  a_ring_write_safe: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> (back_idle && !q_not_empty))
    else $error("ring written during a window read");

endmodule
